// File: rtl/rde_pkg.sv
// Shared types and constants for the radix digit emitter.
package rde_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SEND
  } state_t;

  localparam logic [1:0] CMD_S32 = 2'd0;
  localparam logic [1:0] CMD_U32 = 2'd1;
  localparam logic [1:0] CMD_U64 = 2'd2;

  localparam logic [1:0] CFG_BASE_SIZE  = 2'd0;
  localparam logic [1:0] CFG_CHARS_LOW  = 2'd1;
  localparam logic [1:0] CFG_CHARS_HIGH = 2'd2;

  localparam logic [4:0]  BASE_SIZE_RESET  = 5'd10;
  localparam logic [63:0] CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

  localparam logic [7:0] MINUS_CHAR = 8'h2D;

endpackage

// File: rtl/radix_digit_emitter.sv
// Integer to text converter in a configurable radix, one character per transfer.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | receive   | in_valid / in_stall    | cmd, value
//   out     | send      | out_valid / out_stall  | out_char, last_char, char_count
//   cfg     | receive   | cfg_we                 | cfg_index, cfg_data
//
// Each digit comes from one pass of a shared divider that retires 8 dividend bits a
// cycle, least significant digit first into a digit RAM. Emission reads the RAM back
// most significant digit first, one character per transfer, after a minus sign if negative.
// in_stall is high from the cycle after a transfer until the last character is loaded.
// Reset is synchronous; it clears control state and restores the registers' defaults.
module radix_digit_emitter import rde_pkg::*; #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last_char,
  output logic [6:0]  char_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int PAD_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int DIV_CYC  = PAD_BITS / 8;
  localparam int CNT_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int DIG_W    = $clog2(MAX_RADIX);
  localparam int RAD_W    = $clog2(MAX_RADIX + 1);
  localparam int REM_W    = DIG_W + 1;
  localparam int ADDR_W   = $clog2(VALUE_BITS);
  localparam int NDIG_W   = $clog2(VALUE_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_CYC  = CNT_W'(DIV_CYC - 1);
  localparam logic [4:0]       RADIX_TOP = 5'(MAX_RADIX);

  logic [4:0]  base_size;
  logic [63:0] digit_chars_low;
  logic [63:0] digit_chars_high;

  state_t              state, state_next;
  logic [PAD_BITS-1:0] mag, mag_next;
  logic [DIG_W-1:0]    rem, rem_next;
  logic                neg, neg_next;
  logic [RAD_W-1:0]    radix, radix_next;
  logic [CNT_W-1:0]    cyc, cyc_next;
  logic [NDIG_W-1:0]   ndig, ndig_next;
  logic [ADDR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [6:0]          total, total_next;

  logic [4:0]          base_clamped;
  logic [63:0]         load_mag;
  logic                load_neg;
  logic [PAD_BITS-1:0] div_mag;
  logic [DIG_W-1:0]    div_rem;
  logic                ram_we;
  logic                ram_re;
  logic [DIG_W-1:0]    ram_rdata;
  logic [127:0]        chars;
  logic [3:0]          sym_idx;
  logic [7:0]          sym;
  logic                can_load;
  logic                load_out;
  logic [7:0]          load_char;
  logic                load_last;
  logic [6:0]          load_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size        <= BASE_SIZE_RESET;
      digit_chars_low  <= CHARS_LOW_RESET;
      digit_chars_high <= CHARS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_SIZE:  base_size        <= cfg_data[4:0];
        CFG_CHARS_LOW:  digit_chars_low  <= cfg_data;
        CFG_CHARS_HIGH: digit_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (base_size < 5'd2) begin
      base_clamped = 5'd2;
    end else if (base_size > RADIX_TOP) begin
      base_clamped = RADIX_TOP;
    end else begin
      base_clamped = base_size;
    end
  end

  always_comb begin
    logic [31:0] w32;
    w32      = value[31:0];
    load_neg = 1'b0;
    case (cmd)
      CMD_S32: begin
        load_neg = w32[31];
        load_mag = {32'd0, w32[31] ? (~w32 + 32'd1) : w32};
      end
      CMD_U32: load_mag = {32'd0, w32};
      default: load_mag = 64'(value[VALUE_BITS-1:0]);
    endcase
  end

  always_comb begin
    logic [REM_W-1:0]    r;
    logic [PAD_BITS-1:0] m;
    r = {1'b0, rem};
    m = mag;
    for (int k = 0; k < 8; k++) begin
      r = {r[REM_W-2:0], m[PAD_BITS-1]};
      m = {m[PAD_BITS-2:0], 1'b0};
      if (r >= REM_W'(radix)) begin
        r    = r - REM_W'(radix);
        m[0] = 1'b1;
      end
    end
    div_mag = m;
    div_rem = r[DIG_W-1:0];
  end

  rde_ram #(
    .WIDTH(DIG_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ndig[ADDR_W-1:0]),
    .wdata(div_rem),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  assign chars    = {digit_chars_high, digit_chars_low};
  assign sym_idx  = 4'(ram_rdata);
  assign sym      = chars[{sym_idx, 3'b000} +: 8];
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mag    <= mag_next;
    rem    <= rem_next;
    neg    <= neg_next;
    radix  <= radix_next;
    cyc    <= cyc_next;
    ndig   <= ndig_next;
    rd_ptr <= rd_ptr_next;
    total  <= total_next;
  end

  always_comb begin
    state_next  = state;
    mag_next    = mag;
    rem_next    = rem;
    neg_next    = neg;
    radix_next  = radix;
    cyc_next    = cyc;
    ndig_next   = ndig;
    rd_ptr_next = rd_ptr;
    total_next  = total;
    in_stall    = 1'b1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    load_out    = 1'b0;
    load_char   = sym;
    load_last   = 1'b0;
    load_count  = 7'd0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mag_next   = load_mag[PAD_BITS-1:0];
          neg_next   = load_neg;
          radix_next = base_clamped[RAD_W-1:0];
          rem_next   = '0;
          cyc_next   = '0;
          ndig_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        mag_next = div_mag;
        rem_next = div_rem;
        cyc_next = cyc + CNT_W'(1);
        if (cyc == LAST_CYC) begin
          ram_we    = 1'b1;
          rem_next  = '0;
          cyc_next  = '0;
          ndig_next = ndig + NDIG_W'(1);
          if (div_mag == '0) begin
            rd_ptr_next = ndig[ADDR_W-1:0];
            total_next  = 7'(ndig) + 7'd1 + 7'(neg);
            state_next  = neg ? ST_SIGN : ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          load_out   = 1'b1;
          load_char  = MINUS_CHAR;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (can_load) begin
          load_out = 1'b1;
          if (rd_ptr == '0) begin
            load_last  = 1'b1;
            load_count = total;
            state_next = ST_IDLE;
          end else begin
            rd_ptr_next = rd_ptr - ADDR_W'(1);
            state_next  = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char   <= load_char;
      last_char  <= load_last;
      char_count <= load_count;
    end
  end

endmodule

// File: rtl/rde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rde_checker.sv
// Port-level checker for the radix digit emitter and its bind.
module rde_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        last_char,
  input logic [6:0]  char_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_char)
      && $stable(char_count))
    else $error("stalled output changed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while converting");

  a_count_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_char |-> char_count != 7'd0)
    else $error("final character without count");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_char |-> char_count == 7'd0)
    else $error("count on a non-final character");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);

// File: sim/tb.sv
// Testbench for radix_digit_emitter: random and directed numbers checked against a local predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rde_pkg::*;

  localparam logic [1:0] CMD_U64_ALT = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] num;
  } number_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic       fin;
    logic [6:0] total;
  } char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        last_char;
  logic [6:0]  char_count;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [4:0]  radix_reg = BASE_SIZE_RESET;
  logic [63:0] glyphs_low = CHARS_LOW_RESET;
  logic [63:0] glyphs_high = CHARS_HIGH_RESET;

  number_t pending_numbers[$];
  char_t   expected_chars[$];
  char_t   want_char;

  int send_idle_pct = 7;
  int recv_idle_pct = 48;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int numbers_sent = 0;
  int numbers_done = 0;
  int chars_seen = 0;
  int mismatches = 0;

  radix_digit_emitter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .last_char(last_char), .char_count(char_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Expected characters of one number under the current register settings.
  function automatic void spell_number(logic [1:0] op, logic [63:0] num);
    logic [127:0] alphabet;
    logic [63:0]  mag;
    logic [63:0]  rdx;
    logic [3:0]   d;
    logic [7:0]   digits[$];
    logic         neg;
    int           total;
    alphabet = {glyphs_high, glyphs_low};
    rdx = (radix_reg < 5'd2) ? 64'd2 : (radix_reg > 5'd16) ? 64'd16 : 64'(radix_reg);
    neg = 1'b0;
    case (op)
      CMD_S32: begin
        neg = num[31];
        mag = neg ? {32'd0, (~num[31:0]) + 32'd1} : {32'd0, num[31:0]};
      end
      CMD_U32: mag = {32'd0, num[31:0]};
      default: mag = num;
    endcase
    do begin
      d = 4'(mag % rdx);
      digits.push_front(alphabet[d*8 +: 8]);
      mag = mag / rdx;
    end while (mag != 0);
    total = digits.size() + int'(neg);
    if (neg) expected_chars.push_back('{MINUS_CHAR, 1'b0, 7'd0});
    foreach (digits[i]) begin
      if (i == digits.size() - 1) expected_chars.push_back('{digits[i], 1'b1, 7'(total)});
      else expected_chars.push_back('{digits[i], 1'b0, 7'd0});
    end
  endfunction

  function automatic logic [63:0] random_number();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 20));
      1: return r;
      2: return {r[63:32], 1'b1, r[30:0]};
      default: return r >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic queue_number(logic [1:0] op, logic [63:0] num);
    pending_numbers.push_back('{op, num});
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BASE_SIZE:  radix_reg = data[4:0];
      CFG_CHARS_LOW:  glyphs_low = data;
      CFG_CHARS_HIGH: glyphs_high = data;
      default: ;
    endcase
  endtask

  // Hold the test sequence until every queued number has been spelled out.
  task automatic drain();
    while (pending_numbers.size() != 0 || expected_chars.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input side: advance on each transfer, hold a stalled payload.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        spell_number(cmd, value);
        void'(pending_numbers.pop_front());
        numbers_sent++;
      end
      if (in_valid && in_stall) begin
      end else if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        cmd <= pending_numbers[0].op;
        value <= pending_numbers[0].num;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side back-pressure, with long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_ticket;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: out_char=%h last_char=%b char_count=%0d",
               out_char, last_char, char_count);
        mismatches++;
      end else begin
        want_char = expected_chars.pop_front();
        if (out_char !== want_char.glyph) begin
          $error("out_char: expected %h, got %h", want_char.glyph, out_char);
          mismatches++;
        end
        if (last_char !== want_char.fin) begin
          $error("last_char: expected %b, got %b", want_char.fin, last_char);
          mismatches++;
        end
        if (char_count !== want_char.total) begin
          $error("char_count: expected %0d, got %0d", want_char.total, char_count);
          mismatches++;
        end
        if (want_char.fin) numbers_done++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int bases[12];
    bases = '{10, 2, 16, 0, 17, 1, 31, 3, 7, 11, 15, 10};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults, every mode and its extremes.
    queue_number(CMD_S32, 64'd0);
    queue_number(CMD_S32, 64'd1);
    queue_number(CMD_S32, 64'h0000_0000_7FFF_FFFF);
    queue_number(CMD_S32, 64'h0000_0000_8000_0000);
    queue_number(CMD_S32, 64'h0000_0000_FFFF_FFFF);
    queue_number(CMD_S32, 64'hABCD_0123_8000_0001);
    queue_number(CMD_U32, 64'd0);
    queue_number(CMD_U32, 64'h0000_0000_FFFF_FFFF);
    queue_number(CMD_U32, 64'hFFFF_FFFF_0000_0007);
    queue_number(CMD_U64, 64'd0);
    queue_number(CMD_U64, 64'd1);
    queue_number(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_number(CMD_U64, 64'h8000_0000_0000_0000);
    queue_number(CMD_U64_ALT, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_number(CMD_U64_ALT, 64'd42);
    drain();

    for (int p = 1; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 7;
        recv_idle_pct = 48;
      end else if (p < 8) begin
        send_idle_pct = 48;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_BASE_SIZE, {$urandom, 27'($urandom), 5'(bases[p])});
      if (p == 11) begin
        write_reg(CFG_CHARS_LOW, CHARS_LOW_RESET);
        write_reg(CFG_CHARS_HIGH, CHARS_HIGH_RESET);
      end else if (p % 3 != 0) begin
        write_reg(CFG_CHARS_LOW, {$urandom, $urandom});
        write_reg(CFG_CHARS_HIGH, {$urandom, $urandom});
      end
      if (p == 6) write_reg(CFG_UNUSED, {$urandom, $urandom});
      if (p == 1) begin
        queue_number(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_number(CMD_S32, 64'h0000_0000_8000_0000);
        queue_number(CMD_U32, 64'd0);
      end
      if (p == 2) begin
        queue_number(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_number(CMD_U64, 64'h0123_4567_89AB_CDEF);
      end
      repeat (22) queue_number(2'($urandom_range(0, 3)), random_number());
      if (p == 5 || p == 9) hold_ticket++;
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d numbers in all four modes, %0d characters, radix settings 0 to 31",
             numbers_done, chars_seen);
    $display("with clamping, random alphabets and long output hold-offs; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
